### rtl/core/xmcrc_pkg.sv
// ----------------------------------------------------------------------------
// xmcrc_pkg
// Shared types, character codes and the CRC-16 byte step for the XMODEM-CRC
// receiver core.
// ----------------------------------------------------------------------------
package xmcrc_pkg;

  localparam int unsigned PacketBytes = 128;
  localparam int unsigned OffsetW     = $clog2(PacketBytes);
  localparam int unsigned CfgIdxW     = 4;

  localparam logic [7:0]  ChSoh   = 8'h01;
  localparam logic [7:0]  ChEot   = 8'h04;
  localparam logic [7:0]  ChAck   = 8'h06;
  localparam logic [7:0]  ChNak   = 8'h15;
  localparam logic [7:0]  ChCan   = 8'h18;
  localparam logic [7:0]  ChC     = 8'h43;
  localparam logic [7:0]  ByteAll = 8'hFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0]  HandshakeTriesRst = 8'd20;
  localparam logic [7:0]  PacketTriesRst    = 8'd10;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TMO   = 2'd2,
    OP_FLASH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_CANCEL   = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_TOO_BIG  = 3'd4,
    ST_RETRIES  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEST_ADDR  = 4'd0,
    REG_MAX_LEN    = 4'd1,
    REG_HS_TRIES   = 4'd2,
    REG_PKT_TRIES  = 4'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_HS        = 4'd1,
    PH_BLK       = 4'd2,
    PH_BLKC      = 4'd3,
    PH_BADLEAD   = 4'd4,
    PH_DATA      = 4'd5,
    PH_CRCH      = 4'd6,
    PH_CRCL      = 4'd7,
    PH_RETRYLEAD = 4'd8,
    PH_FLASH     = 4'd9,
    PH_LEAD      = 4'd10,
    PH_DONE      = 4'd11
  } phase_e;

  // one result transaction
  typedef struct packed {
    logic               send_valid;
    logic [7:0]         send_byte;
    logic               stage_valid;
    logic [OffsetW-1:0] stage_offset;
    logic [7:0]         stage_byte;
    logic               commit_valid;
    logic [31:0]        commit_addr;
    logic [2:0]         status;
    logic [31:0]        received_bytes;
    logic               long_wait;
  } result_t;

  // msb-first crc-16, eight shift steps per byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/core/xmcrc_evt_if.sv
// ----------------------------------------------------------------------------
// xmcrc_evt_if
// Event channel into the receiver: op code, received byte, flash status.
// ----------------------------------------------------------------------------
interface xmcrc_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic       flash_ok;

  modport source (output valid, output op, output rx_byte, output flash_ok, input ready);
  modport sink   (input valid, input op, input rx_byte, input flash_ok, output ready);
endinterface

### rtl/core/xmcrc_res_if.sv
// ----------------------------------------------------------------------------
// xmcrc_res_if
// Result channel out of the receiver: transmit byte, staged data, commit and
// session status.
// ----------------------------------------------------------------------------
interface xmcrc_res_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic        stage_valid;
  logic [6:0]  stage_offset;
  logic [7:0]  stage_byte;
  logic        commit_valid;
  logic [31:0] commit_addr;
  logic [2:0]  status;
  logic [31:0] received_bytes;
  logic        long_wait;

  modport source (
    output valid, output send_valid, output send_byte, output stage_valid,
    output stage_offset, output stage_byte, output commit_valid, output commit_addr,
    output status, output received_bytes, output long_wait, input ready
  );
  modport sink (
    input valid, input send_valid, input send_byte, input stage_valid,
    input stage_offset, input stage_byte, input commit_valid, input commit_addr,
    input status, input received_bytes, input long_wait, output ready
  );
endinterface

### rtl/core/xmcrc_cfg_if.sv
// ----------------------------------------------------------------------------
// xmcrc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface xmcrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/xmodem_crc_receiver_core.sv
// result: registered, valid in the cycle after its event transaction is accepted
// throughput: one event per cycle; the result register is refilled as it drains,
//   so a new event is taken whenever the result register is empty or being read
// reset: session state returns to idle, registers take their default values
//   (dest 0, max length 0, 20 handshake tries, 10 packet tries), no result pending
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_core
// XMODEM-CRC receive engine with 128-byte packets, CRC-16 check, data staging
// and flash commit requests.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver_core
  import xmcrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  xmcrc_cfg_if.sink   cfg_i,
  xmcrc_evt_if.sink   evt_i,
  xmcrc_res_if.source res_o
);

  localparam logic [OffsetW-1:0] LastIdx = OffsetW'(PacketBytes - 1);
  localparam logic [31:0]        PktLen  = 32'(PacketBytes);

  // configuration
  logic [31:0] dest_addr_q, max_len_q;
  logic [7:0]  hs_tries_q, pkt_tries_q;

  // session state
  phase_e             phase_q, phase_d;
  logic [7:0]         hs_count_q, hs_count_d;
  logic [7:0]         retry_q, retry_d;
  logic [7:0]         exp_blk_q, exp_blk_d;
  logic [31:0]        total_q, total_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         blk_num_q, blk_num_d;
  logic               blk_fail_q, blk_fail_d;
  logic [OffsetW-1:0] idx_q, idx_d;
  logic [7:0]         crc_hi_q, crc_hi_d;
  logic               data_fail_q, data_fail_d;
  status_e            fstat_q, fstat_d;

  // result register
  logic    res_valid_q;
  result_t res_q, res_d;

  logic evt_fire;
  logic is_byte, is_read;
  logic blkc_bad, crc_bad, too_big;
  op_e  op;

  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign evt_fire    = evt_i.valid && evt_i.ready;

  assign op      = op_e'(evt_i.op);
  assign is_byte = (op == OP_BYTE);
  assign is_read = (op == OP_BYTE) || (op == OP_TMO);

  assign blkc_bad = !is_byte || blk_fail_q ||
                    (({1'b0, blk_num_q} + {1'b0, evt_i.rx_byte}) != {1'b0, ByteAll});
  assign crc_bad  = !is_byte || data_fail_q || ({crc_hi_q, evt_i.rx_byte} != crc_q);
  assign too_big  = ({1'b0, total_q} + {1'b0, PktLen}) > {1'b0, max_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_addr_q <= '0;
      max_len_q   <= '0;
      hs_tries_q  <= HandshakeTriesRst;
      pkt_tries_q <= PacketTriesRst;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_DEST_ADDR: dest_addr_q <= cfg_i.data;
        REG_MAX_LEN:   max_len_q   <= cfg_i.data;
        REG_HS_TRIES:  hs_tries_q  <= cfg_i.data[7:0];
        REG_PKT_TRIES: pkt_tries_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // next session state
  always_comb begin
    phase_d     = phase_q;
    hs_count_d  = hs_count_q;
    retry_d     = retry_q;
    exp_blk_d   = exp_blk_q;
    total_d     = total_q;
    crc_d       = crc_q;
    blk_num_d   = blk_num_q;
    blk_fail_d  = blk_fail_q;
    idx_d       = idx_q;
    crc_hi_d    = crc_hi_q;
    data_fail_d = data_fail_q;
    fstat_d     = fstat_q;

    if (op == OP_START) begin
      total_d     = '0;
      exp_blk_d   = 8'd1;
      retry_d     = '0;
      fstat_d     = ST_BUSY;
      crc_d       = '0;
      blk_num_d   = '0;
      blk_fail_d  = 1'b0;
      idx_d       = '0;
      crc_hi_d    = '0;
      data_fail_d = 1'b0;
      if (hs_tries_q == '0) begin
        hs_count_d = '0;
        phase_d    = PH_DONE;
        fstat_d    = ST_TIMEOUT;
      end else begin
        hs_count_d = 8'd1;
        phase_d    = PH_HS;
      end
    end else begin
      case (phase_q)
        PH_HS: if (is_read) begin
          if (is_byte && evt_i.rx_byte == ChSoh) begin
            retry_d    = '0;
            blk_fail_d = 1'b0;
            if (pkt_tries_q != '0) begin
              phase_d = PH_BLK;
            end else begin
              phase_d = PH_DONE;
              fstat_d = ST_RETRIES;
            end
          end else if (is_byte && evt_i.rx_byte == ChCan) begin
            phase_d = PH_DONE;
            fstat_d = ST_CANCEL;
          end else if (hs_count_q >= hs_tries_q) begin
            phase_d = PH_DONE;
            fstat_d = ST_TIMEOUT;
          end else begin
            hs_count_d = hs_count_q + 8'd1;
          end
        end
        PH_BLK: if (is_read) begin
          if (is_byte) blk_num_d = evt_i.rx_byte;
          else blk_fail_d = 1'b1;
          phase_d = PH_BLKC;
        end
        PH_BLKC: if (is_read) begin
          if (blkc_bad) begin
            retry_d = retry_q + 8'd1;
            phase_d = PH_BADLEAD;
          end else begin
            idx_d       = '0;
            crc_d       = '0;
            data_fail_d = 1'b0;
            phase_d     = PH_DATA;
          end
        end
        PH_BADLEAD, PH_RETRYLEAD: if (is_read) begin
          // after a bad block number only a fresh start byte may follow
          if (phase_q == PH_BADLEAD && !(is_byte && evt_i.rx_byte == ChSoh)) begin
            phase_d = PH_DONE;
            fstat_d = ST_RETRIES;
          end else begin
            blk_fail_d = 1'b0;
            if (retry_q < pkt_tries_q) begin
              phase_d = PH_BLK;
            end else begin
              phase_d = PH_DONE;
              fstat_d = ST_RETRIES;
            end
          end
        end
        PH_DATA: if (is_read) begin
          if (is_byte) begin
            crc_d = crc16_byte(crc_q, evt_i.rx_byte);
            if (idx_q == LastIdx) phase_d = PH_CRCH;
            else idx_d = idx_q + OffsetW'(1);
          end else begin
            data_fail_d = 1'b1;
            phase_d     = PH_CRCH;
          end
        end
        PH_CRCH: if (is_read) begin
          if (is_byte) crc_hi_d = evt_i.rx_byte;
          else data_fail_d = 1'b1;
          phase_d = PH_CRCL;
        end
        PH_CRCL: if (is_read) begin
          if (crc_bad) begin
            retry_d = retry_q + 8'd1;
            phase_d = PH_RETRYLEAD;
          end else if (blk_num_q == exp_blk_q) begin
            if (too_big) begin
              phase_d = PH_DONE;
              fstat_d = ST_TOO_BIG;
            end else begin
              phase_d = PH_FLASH;
            end
          end else begin
            phase_d = PH_LEAD;
          end
        end
        PH_FLASH: if (op == OP_FLASH) begin
          if (evt_i.flash_ok) begin
            total_d   = total_q + PktLen;
            exp_blk_d = exp_blk_q + 8'd1;
            phase_d   = PH_LEAD;
          end else begin
            phase_d = PH_DONE;
            fstat_d = ST_TIMEOUT;
          end
        end
        PH_LEAD: if (is_read) begin
          if (is_byte && evt_i.rx_byte == ChEot) begin
            phase_d = PH_DONE;
            fstat_d = ST_OK;
          end else if (is_byte && evt_i.rx_byte == ChCan) begin
            phase_d = PH_DONE;
            fstat_d = ST_CANCEL;
          end else if (is_byte && evt_i.rx_byte == ChSoh) begin
            retry_d    = '0;
            blk_fail_d = 1'b0;
            if (pkt_tries_q != '0) begin
              phase_d = PH_BLK;
            end else begin
              phase_d = PH_DONE;
              fstat_d = ST_RETRIES;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result of the current transaction
  always_comb begin
    res_d                = '0;
    res_d.status         = (phase_d == PH_DONE) ? fstat_d : ST_BUSY;
    res_d.received_bytes = total_d;
    res_d.long_wait      = (phase_d == PH_HS);

    if (op == OP_START) begin
      if (hs_tries_q != '0) begin
        res_d.send_valid = 1'b1;
        res_d.send_byte  = ChC;
      end
    end else begin
      case (phase_q)
        PH_HS: if (is_read && !(is_byte && (evt_i.rx_byte == ChSoh ||
                                            evt_i.rx_byte == ChCan)) &&
                   hs_count_q < hs_tries_q) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = ChC;
        end
        PH_BLKC: if (is_read && blkc_bad) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = ChNak;
        end
        PH_DATA: if (is_byte) begin
          res_d.stage_valid  = 1'b1;
          res_d.stage_offset = idx_q;
          res_d.stage_byte   = evt_i.rx_byte;
        end
        PH_CRCL: if (is_read) begin
          if (crc_bad) begin
            res_d.send_valid = 1'b1;
            res_d.send_byte  = ChNak;
          end else if (blk_num_q == exp_blk_q) begin
            if (!too_big) begin
              res_d.commit_valid = 1'b1;
              res_d.commit_addr  = dest_addr_q + total_q;
            end
          end else begin
            // block number other than the expected one (e.g. a duplicate), acknowledged without a write
            res_d.send_valid = 1'b1;
            res_d.send_byte  = ChAck;
          end
        end
        PH_FLASH: if (op == OP_FLASH && evt_i.flash_ok) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = ChAck;
        end
        PH_LEAD: if (is_read) begin
          if (is_byte && evt_i.rx_byte == ChEot) begin
            res_d.send_valid = 1'b1;
            res_d.send_byte  = ChAck;
          end else if (!(is_byte && (evt_i.rx_byte == ChCan ||
                                     evt_i.rx_byte == ChSoh))) begin
            res_d.send_valid = 1'b1;
            res_d.send_byte  = ChNak;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hs_count_q  <= '0;
      retry_q     <= '0;
      exp_blk_q   <= 8'd1;
      total_q     <= '0;
      crc_q       <= '0;
      blk_num_q   <= '0;
      blk_fail_q  <= 1'b0;
      idx_q       <= '0;
      crc_hi_q    <= '0;
      data_fail_q <= 1'b0;
      fstat_q     <= ST_BUSY;
    end else if (evt_fire) begin
      phase_q     <= phase_d;
      hs_count_q  <= hs_count_d;
      retry_q     <= retry_d;
      exp_blk_q   <= exp_blk_d;
      total_q     <= total_d;
      crc_q       <= crc_d;
      blk_num_q   <= blk_num_d;
      blk_fail_q  <= blk_fail_d;
      idx_q       <= idx_d;
      crc_hi_q    <= crc_hi_d;
      data_fail_q <= data_fail_d;
      fstat_q     <= fstat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (evt_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.send_valid     = res_q.send_valid;
  assign res_o.send_byte      = res_q.send_byte;
  assign res_o.stage_valid    = res_q.stage_valid;
  assign res_o.stage_offset   = res_q.stage_offset;
  assign res_o.stage_byte     = res_q.stage_byte;
  assign res_o.commit_valid   = res_q.commit_valid;
  assign res_o.commit_addr    = res_q.commit_addr;
  assign res_o.status         = res_q.status;
  assign res_o.received_bytes = res_q.received_bytes;
  assign res_o.long_wait      = res_q.long_wait;

endmodule
